// ----- hdl/txcon_pkg.sv -----
// txcon_pkg: screen geometry, field widths, character and command codes
// for the text console cursor writer. No dependencies.
package txcon_pkg;

   localparam int COLUMNS   = 80;
   localparam int ROWS      = 25;
   localparam int TAB_WIDTH = 8;
   localparam int CELLS     = COLUMNS * ROWS;

   // request/response field widths
   localparam int CMD_W   = 2;
   localparam int CHAR_W  = 8;
   localparam int COLOR_W = 4;
   localparam int ADDR_W  = 11;
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int CELL_W  = 16;

   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

   localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

endpackage

// ----- hdl/txcon_channels.sv -----
// txcon request and response channel interfaces (valid/ready plus payload).
// Depends on txcon_pkg for field widths.
interface txcon_req_if;
   logic                              valid;
   logic                              ready;
   logic [txcon_pkg::CMD_W-1:0]       cmd;
   logic [txcon_pkg::CHAR_W-1:0]      char_code;
   logic [txcon_pkg::COLOR_W-1:0]     back_color;
   logic [txcon_pkg::COLOR_W-1:0]     fore_color;
   logic [txcon_pkg::ADDR_W-1:0]      read_address;

   modport source (output valid, cmd, char_code, back_color, fore_color, read_address,
                   input ready);
   modport sink   (input valid, cmd, char_code, back_color, fore_color, read_address,
                   output ready);
endinterface

interface txcon_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [txcon_pkg::COL_W-1:0]       cursor_column;
   logic [txcon_pkg::ROW_W-1:0]       cursor_row;
   logic [txcon_pkg::ADDR_W-1:0]      cursor_offset;
   logic                              cell_written;
   logic [txcon_pkg::ADDR_W-1:0]      cell_address;
   logic [txcon_pkg::CELL_W-1:0]      cell_value;
   logic                              scrolled;
   logic [txcon_pkg::CELL_W-1:0]      read_data;

   modport source (output valid, cursor_column, cursor_row, cursor_offset, cell_written,
                   cell_address, cell_value, scrolled, read_data,
                   input ready);
   modport sink   (input valid, cursor_column, cursor_row, cursor_offset, cell_written,
                   cell_address, cell_value, scrolled, read_data,
                   output ready);
endinterface

// ----- hdl/txcon_ram.sv -----
// txcon_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module txcon_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/text_console_cursor_writer_top.sv -----
// text_console_cursor_writer_top: text screen store with cursor, scroll and clear.
// Depends on txcon_pkg, txcon_channels (txcon_req_if, txcon_rsp_if) and txcon_ram.
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+---------------------------------------------
//   req_if   | in  | valid / ready  | cmd, char_code, back_color, fore_color,
//            |     |                | read_address
//   rsp_if   | out | valid / ready  | cursor_column, cursor_row, cursor_offset,
//            |     |                | cell_written, cell_address, cell_value,
//            |     |                | scrolled, read_data
//
// Sequence: write (no scroll), read and no-op requests go from IDLE straight to DONE;
//   a write that scrolls copies rows up (SCROLL), each cell passing through the RAM's
//   registered read, then blanks the last row (BLANK); clear blanks all CELLS cells
//   (CLEAR). All sweeps go through the one shared address counter.
// Reset: synchronous; afterwards the block sweeps blank into all CELLS cells (2000 at
//   80x25) before it takes the first request.
// Stalls: the response sits in an output register, so a new request is taken while
//   the previous response waits; a finished request waits in DONE for that register.
module text_console_cursor_writer_top (
   input  logic        clock,
   input  logic        reset,
   txcon_req_if.sink   req_if,
   txcon_rsp_if.source rsp_if
);

   localparam int ADDR_W = txcon_pkg::ADDR_W;
   localparam int COL_W  = txcon_pkg::COL_W;
   localparam int ROW_W  = txcon_pkg::ROW_W;
   localparam int CELL_W = txcon_pkg::CELL_W;

   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(txcon_pkg::CELLS - 1);
   localparam logic [ADDR_W-1:0] COPY_END  =
      ADDR_W'(txcon_pkg::CELLS - txcon_pkg::COLUMNS);

   typedef enum logic [2:0] {
      S_INIT,    // post-reset blanking sweep
      S_IDLE,
      S_SCROLL,  // copy row r+1 to row r, one cell per cycle
      S_BLANK,   // blank the last row after the copy
      S_CLEAR,   // clear command sweep
      S_DONE     // hand result to the output register
   } state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in;   // shared sweep address counter
   logic               pend_ff, pend_in;     // copy data waiting on RAM output
   logic [COL_W-1:0]   cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]   cur_row_ff, cur_row_in;

   // per-request results held until the response register frees up
   logic               res_written_ff, res_written_in;
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in;
   logic [CELL_W-1:0]  res_value_ff, res_value_in;
   logic               res_scrolled_ff, res_scrolled_in;
   logic               rd_hit_ff, rd_hit_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]   rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]   rsp_row_ff, rsp_row_in;
   logic [ADDR_W-1:0]  rsp_offset_ff, rsp_offset_in;
   logic               rsp_written_ff, rsp_written_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [CELL_W-1:0]  rsp_value_ff, rsp_value_in;
   logic               rsp_scrolled_ff, rsp_scrolled_in;
   logic [CELL_W-1:0]  rsp_rdata_ff, rsp_rdata_in;

   // RAM port
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [CELL_W-1:0]  ram_wdata;
   logic               ram_re;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [CELL_W-1:0]  ram_rdata;

   logic [ADDR_W-1:0]  cur_offset;
   logic               rsp_free;
   logic [COL_W-1:0]   new_col;
   logic [ROW_W-1:0]   new_row;
   logic               printable;

   txcon_ram #(
      .WIDTH (CELL_W),
      .DEPTH (txcon_pkg::CELLS)
   ) u_screen (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Cursor cell index; before an update this is the write address, after it
   // this is the reported offset.
   assign cur_offset = ADDR_W'(cur_row_ff * txcon_pkg::COLUMNS) + ADDR_W'(cur_col_ff);
   assign rsp_free   = !rsp_valid_ff || rsp_if.ready;
   assign printable  = req_if.char_code inside {[txcon_pkg::CH_SPACE:txcon_pkg::CH_DEL]};

   assign req_if.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in        = state_ff;
      sweep_in        = sweep_ff;
      pend_in         = pend_ff;
      cur_col_in      = cur_col_ff;
      cur_row_in      = cur_row_ff;
      res_written_in  = res_written_ff;
      res_addr_in     = res_addr_ff;
      res_value_in    = res_value_ff;
      res_scrolled_in = res_scrolled_ff;
      rd_hit_in       = rd_hit_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_col_in      = rsp_col_ff;
      rsp_row_in      = rsp_row_ff;
      rsp_offset_in   = rsp_offset_ff;
      rsp_written_in  = rsp_written_ff;
      rsp_addr_in     = rsp_addr_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      rsp_rdata_in    = rsp_rdata_ff;
      ram_we          = 1'b0;
      ram_waddr       = sweep_ff;
      ram_wdata       = txcon_pkg::BLANK_CELL;
      ram_re          = 1'b0;
      ram_raddr       = req_if.read_address;
      new_col         = cur_col_ff;
      new_row         = cur_row_ff;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_INIT: begin
            ram_we = 1'b1;
            if (sweep_ff == LAST_CELL) begin
               sweep_in = '0;
               state_in = S_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (req_if.valid) begin
               res_written_in  = 1'b0;
               res_addr_in     = '0;
               res_value_in    = '0;
               res_scrolled_in = 1'b0;
               rd_hit_in       = 1'b0;
               sweep_in        = '0;
               pend_in         = 1'b0;
               state_in        = S_DONE;
               case (req_if.cmd)
                  txcon_pkg::CMD_WRITE: begin
                     case (req_if.char_code)
                        txcon_pkg::CH_BS: begin
                           if (cur_col_ff != '0) begin
                              new_col = cur_col_ff - 1'b1;
                           end
                        end
                        txcon_pkg::CH_TAB: begin
                           new_col = (cur_col_ff & ~COL_W'(txcon_pkg::TAB_WIDTH - 1))
                                     + COL_W'(txcon_pkg::TAB_WIDTH);
                        end
                        txcon_pkg::CH_CR: begin
                           new_col = '0;
                        end
                        txcon_pkg::CH_LF: begin
                           new_col = '0;
                           new_row = cur_row_ff + 1'b1;
                        end
                        default: begin
                           if (printable) begin
                              ram_we         = 1'b1;
                              ram_waddr      = cur_offset;
                              ram_wdata      = {req_if.back_color, req_if.fore_color,
                                                req_if.char_code};
                              res_written_in = 1'b1;
                              res_addr_in    = cur_offset;
                              res_value_in   = ram_wdata;
                              new_col        = cur_col_ff + 1'b1;
                           end
                        end
                     endcase
                     // line wrap
                     if (new_col >= COL_W'(txcon_pkg::COLUMNS)) begin
                        new_col = '0;
                        new_row = new_row + 1'b1;
                     end
                     // past the bottom row: scroll, cursor stays on last row
                     if (new_row == ROW_W'(txcon_pkg::ROWS)) begin
                        new_row         = ROW_W'(txcon_pkg::ROWS - 1);
                        res_scrolled_in = 1'b1;
                        state_in        = S_SCROLL;
                     end
                     cur_col_in = new_col;
                     cur_row_in = new_row;
                  end
                  txcon_pkg::CMD_CLEAR: begin
                     cur_col_in = '0;
                     cur_row_in = '0;
                     state_in   = S_CLEAR;
                  end
                  txcon_pkg::CMD_READ: begin
                     ram_re    = 1'b1;
                     rd_hit_in = (req_if.read_address < ADDR_W'(txcon_pkg::CELLS));
                  end
                  default: begin
                     // unused command: report the cursor only
                  end
               endcase
            end
         end

         S_SCROLL: begin
            // read cell sweep+COLUMNS, write the cell read last cycle to sweep-1
            ram_we    = pend_ff;
            ram_waddr = sweep_ff - 1'b1;
            ram_wdata = ram_rdata;
            if (sweep_ff != COPY_END) begin
               ram_re    = 1'b1;
               ram_raddr = sweep_ff + ADDR_W'(txcon_pkg::COLUMNS);
               sweep_in  = sweep_ff + 1'b1;
               pend_in   = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = S_BLANK;
            end
         end

         S_BLANK: begin
            ram_we = 1'b1;
            if (sweep_ff == LAST_CELL) begin
               state_in = S_DONE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end

         S_CLEAR: begin
            ram_we = 1'b1;
            if (sweep_ff == LAST_CELL) begin
               state_in = S_DONE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end

         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_col_in      = cur_col_ff;
               rsp_row_in      = cur_row_ff;
               rsp_offset_in   = cur_offset;
               rsp_written_in  = res_written_ff;
               rsp_addr_in     = res_addr_ff;
               rsp_value_in    = res_value_ff;
               rsp_scrolled_in = res_scrolled_ff;
               rsp_rdata_in    = rd_hit_ff ? ram_rdata : '0;
               state_in        = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         sweep_ff     <= '0;
         pend_ff      <= 1'b0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         pend_ff      <= pend_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_written_ff  <= res_written_in;
      res_addr_ff     <= res_addr_in;
      res_value_ff    <= res_value_in;
      res_scrolled_ff <= res_scrolled_in;
      rd_hit_ff       <= rd_hit_in;
      rsp_col_ff      <= rsp_col_in;
      rsp_row_ff      <= rsp_row_in;
      rsp_offset_ff   <= rsp_offset_in;
      rsp_written_ff  <= rsp_written_in;
      rsp_addr_ff     <= rsp_addr_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
      rsp_rdata_ff    <= rsp_rdata_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.cursor_column = rsp_col_ff;
   assign rsp_if.cursor_row    = rsp_row_ff;
   assign rsp_if.cursor_offset = rsp_offset_ff;
   assign rsp_if.cell_written  = rsp_written_ff;
   assign rsp_if.cell_address  = rsp_addr_ff;
   assign rsp_if.cell_value    = rsp_value_ff;
   assign rsp_if.scrolled      = rsp_scrolled_ff;
   assign rsp_if.read_data     = rsp_rdata_ff;

`ifndef SYNTHESIS
   a_ram_addr_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (ram_waddr <= LAST_CELL))
      else $error("screen write address out of range");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |->
         (cur_col_ff < COL_W'(txcon_pkg::COLUMNS)) && (cur_row_ff < ROW_W'(txcon_pkg::ROWS)))
      else $error("cursor outside the screen while idle");

   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_scrolled_ff) |-> (rsp_row_ff == ROW_W'(txcon_pkg::ROWS - 1)))
      else $error("scroll reported with cursor off the last row");

   a_written_printable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_written_ff) |->
         (rsp_value_ff[7:0] >= txcon_pkg::CH_SPACE) && (rsp_value_ff[7:0] <= txcon_pkg::CH_DEL))
      else $error("stored cell holds a non-printable byte");

   a_copy_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCROLL && sweep_ff == COPY_END) |=> (state_ff == S_BLANK && !pend_ff))
      else $error("scroll copy did not drain before blanking");
`endif

endmodule
